[rtl/i2dt_pkg.sv]
// shared constants, job type and bcd helpers for the integer to decimal text core
// no dependencies; every other file imports this package
package i2dt_pkg;

    localparam int IN_BITS    = 64;
    localparam int VALUE_BITS = 64;
    // decimal digits needed for 2^VALUE_BITS - 1
    localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS   = DIGITS * 4;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int DCNT_W     = $clog2(DIGITS + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } t_job;

    // add three to every digit of five or more, ahead of the shift
    function automatic logic [BCD_BITS-1:0] bcd_adjust(input logic [BCD_BITS-1:0] b);
        logic [BCD_BITS-1:0] r;
        r = b;
        for (int i = 0; i < DIGITS; i++) begin
            if (b[4*i +: 4] >= 4'd5) begin
                r[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    // every digit a legal decimal digit
    function automatic logic bcd_ok(input logic [BCD_BITS-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (b[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

[rtl/i2dt_if.sv]
// valid/ready channel interfaces for integers in and characters out
// depends on i2dt_pkg
interface i2dt_in_if;
    import i2dt_pkg::*;
    logic               valid;
    logic               ready;
    logic [IN_BITS-1:0] value;
    logic               is_signed;
    modport source (output valid, output value, output is_signed, input ready);
    modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface i2dt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last;
    modport source (output valid, output text_char, output last, input ready);
    modport sink   (input valid, input text_char, input last, output ready);
endinterface

[rtl/i2dt_front.sv]
// front end: accepts integers, takes the sign and forms the magnitude
// depends on i2dt_pkg and i2dt_if
module i2dt_front (
    i2dt_in_if.sink         i_item,
    input  logic            i_full,
    output logic            o_push,
    output i2dt_pkg::t_job  o_job
);
    import i2dt_pkg::*;

    logic [VALUE_BITS-1:0] x;
    logic                  neg;

    assign x   = i_item.value[VALUE_BITS-1:0];
    assign neg = i_item.is_signed & x[VALUE_BITS-1];

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;
    assign o_job.neg    = neg;
    // most negative value wraps onto its own unsigned magnitude
    assign o_job.mag    = neg ? ((~x) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : x;

endmodule

[rtl/i2dt_queue.sv]
// short job queue between front and back end
// depends on i2dt_pkg
module i2dt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2dt_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output i2dt_pkg::t_job  o_job,
    output logic            o_empty
);
    import i2dt_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

[rtl/i2dt_back.sv]
// back end: bit-serial double dabble, leading zero skip and character output
// depends on i2dt_pkg and i2dt_if
module i2dt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  i2dt_pkg::t_job  i_job,
    output logic            o_pop,
    i2dt_out_if.source      o_char
);
    import i2dt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SKIP  = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    logic [2:0]            r_state, n_state;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCD_BITS-1:0]   r_bcd, n_bcd;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DCNT_W-1:0]     r_dcnt, n_dcnt;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic                  can_emit;
    logic [3:0]            top;
    logic [BCD_BITS-1:0]   adj;

    assign can_emit = !r_out_valid || o_char.ready;
    assign top      = r_bcd[BCD_BITS-1 -: 4];
    assign adj      = bcd_adjust(r_bcd);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    assign o_char.valid     = r_out_valid;
    assign o_char.text_char = r_out_char;
    assign o_char.last      = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid && !o_char.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_neg   = i_job.neg;
                    n_bin   = i_job.mag;
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(VALUE_BITS);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {adj[BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_dcnt  = DCNT_W'(DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top == 4'd0 && r_dcnt != DCNT_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_BITS-5:0], 4'd0};
                    n_dcnt = r_dcnt - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_ZERO + {4'd0, top};
                    n_out_last  = (r_dcnt == DCNT_W'(1));
                    n_bcd       = {r_bcd[BCD_BITS-5:0], 4'd0};
                    n_dcnt      = r_dcnt - 1'b1;
                    if (r_dcnt == DCNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_dcnt     <= n_dcnt;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

`ifndef SYNTHESIS
    a_bcd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_DIGIT) |-> bcd_ok(r_bcd))
        else $error("illegal bcd digit after conversion");
    a_sign_only_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN) |-> r_neg)
        else $error("sign state for a non-negative value");
    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SKIP || r_state == S_SIGN || r_state == S_DIGIT) |-> (r_dcnt != '0))
        else $error("digit count ran out");
`endif

endmodule

[rtl/integer_to_decimal_text_core.sv]
// integer to decimal text core: an accepted number passes through the queue, then the back end
// converts it one bit a cycle by double dabble, skips leading zero digits (at most DIGITS - 1),
// sends a minus sign for a negative number and then the digits; output stalls hold the characters
// the back end takes no new number until the last character is loaded into its output register
// the front end takes further numbers into a two-entry queue while the back end works
// synchronous active-low reset empties the queue, idles the back end and drops any pending character
module integer_to_decimal_text_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2dt_in_if.sink    i_item,
    i2dt_out_if.source o_char
);
    import i2dt_pkg::*;

    // front to queue
    logic push;
    logic full;
    t_job push_job;

    // queue to back end
    logic pop;
    logic empty;
    t_job pop_job;

    // sign detection and two's complement magnitude, straight into the queue
    i2dt_front u_front (
        .i_item (i_item),
        .i_full (full),
        .o_push (push),
        .o_job  (push_job)
    );

    // two jobs of slack so the sender is not held while a number is printed
    i2dt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    // binary to bcd one bit a cycle, then leading zeros dropped and
    // characters sent out through a registered output word
    i2dt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (pop_job),
        .o_pop   (pop),
        .o_char  (o_char)
    );

endmodule
